>>> rtl/tocp_pkg.sv
// Package for the topology-ordered CPU placement unit.
// Holds the shared widths, register and status codes, the controller state type and helpers.
// No dependencies.
`default_nettype none

package tocp_pkg;

  localparam int NODE_MAX_DEF   = 4;
  localparam int TILE_MAX_DEF   = 4;
  localparam int CORE_MAX_DEF   = 8;
  localparam int THREAD_MAX_DEF = 4;
  localparam int CPU_COUNT_DEF  = 64;

  localparam int MASK_W    = 64;
  localparam int ID_W      = 6;
  localparam int CFG_W     = 4;
  localparam int CFG_IDX_W = 2;
  localparam int NDIM      = 4;

  // Configuration register indexes, which double as dimension codes.
  localparam logic [CFG_IDX_W-1:0] CFG_NODE   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_TILE   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_CORE   = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_THREAD = 2'd3;

  localparam logic [CFG_W-1:0] CFG_NODE_RST   = 4'd4;
  localparam logic [CFG_W-1:0] CFG_TILE_RST   = 4'd4;
  localparam logic [CFG_W-1:0] CFG_CORE_RST   = 4'd8;
  localparam logic [CFG_W-1:0] CFG_THREAD_RST = 4'd4;

  localparam logic REQ_WRITE = 1'b0;
  localparam logic REQ_RUN   = 1'b1;

  localparam logic [1:0] ST_PLACED    = 2'd0;
  localparam logic [1:0] ST_BAD       = 2'd1;
  localparam logic [1:0] ST_UNPLACED  = 2'd2;
  localparam logic [1:0] ST_EMPTY     = 2'd3;

  typedef enum logic [2:0] {
    S_IDLE,
    S_ERR,
    S_READ,
    S_LOOK,
    S_STRIP,
    S_REPORT
  } state_e;

  // Index of the lowest set bit, zero when the mask is empty.
  function automatic logic [ID_W-1:0] lowest_bit(input logic [MASK_W-1:0] m);
    logic [ID_W-1:0] r;
    r = '0;
    for (int b = MASK_W - 1; b >= 0; b--) begin
      if (m[b]) begin
        r = ID_W'(b);
      end
    end
    return r;
  endfunction

endpackage

`default_nettype wire

>>> rtl/topology_ordered_cpu_placement_unit.sv
// Top level of the topology-ordered CPU placement unit.
// Depends on tocp_pkg and tocp_ram.
//
//   channel   handshake            payload
//   config    cfg_we_i             cfg_idx_i, cfg_data_i
//   request   start && !busy       req_type_i, map_*, core_cpus_i, requested_cpus_i,
//                                  dim_order_i, *_limit_i
//   result    result_valid_o       cpu_id_o, status_o, last_o
//
// A map write is a single-cycle beat and leaves the unit idle. A run visits each counter
// position through map read (S_READ), read data (S_LOOK) and pick (S_STRIP); before the
// pick, S_STRIP drops the set bits below the thread index one by one in a serial nth-bit
// search. A run covers at most two sweeps (limited, then full); unplaced CPUs are then
// reported one per cycle. Reset is asynchronous and clears the control state and the map
// valid bits; no clearing pass is needed. Results cannot be stalled.
`default_nettype none

module topology_ordered_cpu_placement_unit #(
  parameter int NODE_MAX   = tocp_pkg::NODE_MAX_DEF,
  parameter int TILE_MAX   = tocp_pkg::TILE_MAX_DEF,
  parameter int CORE_MAX   = tocp_pkg::CORE_MAX_DEF,
  parameter int THREAD_MAX = tocp_pkg::THREAD_MAX_DEF,
  parameter int CPU_COUNT  = tocp_pkg::CPU_COUNT_DEF
) (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           cfg_we_i,
  input  wire logic [tocp_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  wire logic [tocp_pkg::CFG_W-1:0]     cfg_data_i,
  input  wire logic                           start,
  output logic                                busy,
  input  wire logic                           req_type_i,
  input  wire logic [1:0]                     map_node_i,
  input  wire logic [1:0]                     map_tile_i,
  input  wire logic [2:0]                     map_core_i,
  input  wire logic [tocp_pkg::MASK_W-1:0]    core_cpus_i,
  input  wire logic [tocp_pkg::MASK_W-1:0]    requested_cpus_i,
  input  wire logic [7:0]                     dim_order_i,
  input  wire logic [2:0]                     node_limit_i,
  input  wire logic [2:0]                     tile_limit_i,
  input  wire logic [3:0]                     core_limit_i,
  input  wire logic [2:0]                     thread_limit_i,
  output logic                                result_valid_o,
  output logic      [tocp_pkg::ID_W-1:0]      cpu_id_o,
  output logic      [1:0]                     status_o,
  output logic                                last_o
);

  import tocp_pkg::*;

  localparam int DEPTH = NODE_MAX * TILE_MAX * CORE_MAX;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int DMAX01 = (NODE_MAX > TILE_MAX) ? NODE_MAX : TILE_MAX;
  localparam int DMAX23 = (CORE_MAX > THREAD_MAX) ? CORE_MAX : THREAD_MAX;
  localparam int DMAX   = (DMAX01 > DMAX23) ? DMAX01 : DMAX23;
  localparam int DW     = $clog2(DMAX + 1);
  localparam logic [MASK_W-1:0] CMASK =
    (CPU_COUNT >= MASK_W) ? '1 : ((MASK_W'(1) << CPU_COUNT) - MASK_W'(1));
  localparam int DIM_MAX [NDIM] = '{NODE_MAX, TILE_MAX, CORE_MAX, THREAD_MAX};

  // Configuration registers, one per dimension.
  logic [CFG_W-1:0] cfg_q [NDIM];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q[CFG_NODE]   <= CFG_NODE_RST;
      cfg_q[CFG_TILE]   <= CFG_TILE_RST;
      cfg_q[CFG_CORE]   <= CFG_CORE_RST;
      cfg_q[CFG_THREAD] <= CFG_THREAD_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_NODE:   cfg_q[CFG_NODE]   <= {1'b0, cfg_data_i[2:0]};
        CFG_TILE:   cfg_q[CFG_TILE]   <= {1'b0, cfg_data_i[2:0]};
        CFG_CORE:   cfg_q[CFG_CORE]   <= cfg_data_i;
        CFG_THREAD: cfg_q[CFG_THREAD] <= {1'b0, cfg_data_i[2:0]};
        default: ;
      endcase
    end
  end

  // Effective extents: zero reads as one, anything above the build maximum is clipped.
  logic [DW-1:0] ext [NDIM];

  always_comb begin
    for (int d = 0; d < NDIM; d++) begin
      if (cfg_q[d] == '0) begin
        ext[d] = DW'(1);
      end else if (int'(cfg_q[d]) > DIM_MAX[d]) begin
        ext[d] = DW'(DIM_MAX[d]);
      end else begin
        ext[d] = DW'(cfg_q[d]);
      end
    end
  end

  // Request decode for a run beat.
  logic [3:0]    lim_in [NDIM];
  logic [DW-1:0] lim_sel [NDIM];
  logic          lim_bad;
  logic [3:0]    seen;
  logic          run_bad;
  logic [MASK_W-1:0] req_mask;

  always_comb begin
    lim_in[CFG_NODE]   = {1'b0, node_limit_i};
    lim_in[CFG_TILE]   = {1'b0, tile_limit_i};
    lim_in[CFG_CORE]   = core_limit_i;
    lim_in[CFG_THREAD] = {1'b0, thread_limit_i};
    lim_bad = 1'b0;
    for (int d = 0; d < NDIM; d++) begin
      if (lim_in[d] == '0) begin
        lim_sel[d] = ext[d];
      end else begin
        lim_sel[d] = DW'(lim_in[d]);
        if (int'(lim_in[d]) > int'(ext[d])) begin
          lim_bad = 1'b1;
        end
      end
    end
    seen = '0;
    for (int i = 0; i < NDIM; i++) begin
      seen[dim_order_i[2*i +: 2]] = 1'b1;
    end
    run_bad  = lim_bad || (seen != 4'hF);
    req_mask = requested_cpus_i & CMASK;
  end

  // Walk state.
  state_e            state_q, state_d;
  logic [7:0]        order_q;
  logic [DW-1:0]     pos_q [NDIM];
  logic [DW-1:0]     pos_n [NDIM];
  logic [DW-1:0]     lim_q [NDIM];
  logic [MASK_W-1:0] rem_q, rem_d;
  logic [MASK_W-1:0] mask_q, mask_d;
  logic [DW-1:0]     cnt_q, cnt_d;
  logic [1:0]        err_q;
  logic              vld_q [DEPTH];
  logic              vld_hit_q;

  logic accept;
  logic map_ok;
  logic [AW-1:0] waddr, raddr;
  logic [MASK_W-1:0] rdata;

  assign busy   = (state_q != S_IDLE);
  assign accept = start && !busy;
  assign map_ok = (int'(map_node_i) < NODE_MAX) && (int'(map_tile_i) < TILE_MAX) &&
                  (int'(map_core_i) < CORE_MAX);
  assign waddr  = AW'((int'(map_node_i) * TILE_MAX + int'(map_tile_i)) * CORE_MAX +
                      int'(map_core_i));
  assign raddr  = AW'((int'(pos_q[CFG_NODE]) * TILE_MAX + int'(pos_q[CFG_TILE])) *
                      CORE_MAX + int'(pos_q[CFG_CORE]));

  tocp_ram #(
    .WIDTH (MASK_W),
    .DEPTH (DEPTH),
    .AW    (AW)
  ) u_map (
    .clk_i   (clk_i),
    .we_i    (accept && (req_type_i == REQ_WRITE) && map_ok),
    .waddr_i (waddr),
    .wdata_i (core_cpus_i),
    .re_i    (state_q == S_READ),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  // Pick, report and advance logic; S_STRIP picks once the thread count is used up.
  logic [ID_W-1:0]   pick_cpu;
  logic              pick_hit;
  logic [MASK_W-1:0] rem_after;
  logic              carry;
  logic              origin;
  logic              full;
  logic [ID_W-1:0]   rep_cpu;
  logic [MASK_W-1:0] rep_after;

  always_comb begin
    pick_cpu  = lowest_bit(mask_q);
    pick_hit  = (mask_q != '0) && rem_q[pick_cpu];
    rem_after = pick_hit ? (rem_q & ~(MASK_W'(1) << pick_cpu)) : rem_q;
    rep_cpu   = lowest_bit(rem_q);
    rep_after = rem_q & ~(MASK_W'(1) << rep_cpu);

    // Mixed-radix increment in the latched dimension order.
    pos_n = pos_q;
    carry = 1'b1;
    for (int i = 0; i < NDIM; i++) begin
      if (carry) begin
        if (({1'b0, pos_n[order_q[2*i +: 2]]} + (DW+1)'(1)) <
            {1'b0, lim_q[order_q[2*i +: 2]]}) begin
          pos_n[order_q[2*i +: 2]] = pos_n[order_q[2*i +: 2]] + DW'(1);
          carry = 1'b0;
        end else begin
          pos_n[order_q[2*i +: 2]] = '0;
        end
      end
    end
    origin = 1'b1;
    full   = 1'b1;
    for (int d = 0; d < NDIM; d++) begin
      if (pos_n[d] != '0) origin = 1'b0;
      if (lim_q[d] != ext[d]) full = 1'b0;
    end
  end

  // Next-state logic.
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (accept && (req_type_i == REQ_RUN)) begin
          state_d = (run_bad || (req_mask == '0)) ? S_ERR : S_READ;
        end
      end
      S_ERR:  state_d = S_IDLE;
      S_READ: state_d = S_LOOK;
      S_LOOK: state_d = S_STRIP;
      S_STRIP: begin
        if (cnt_q == '0) begin
          if (rem_after == '0) begin
            state_d = S_IDLE;
          end else if (origin && full) begin
            state_d = S_REPORT;
          end else begin
            state_d = S_READ;
          end
        end
      end
      S_REPORT: begin
        if (rep_after == '0) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // Output and datapath logic.
  logic              emit;
  logic [ID_W-1:0]   emit_cpu;
  logic [1:0]        emit_st;
  logic              emit_last;

  always_comb begin
    emit      = 1'b0;
    emit_cpu  = '0;
    emit_st   = ST_PLACED;
    emit_last = 1'b0;
    rem_d     = rem_q;
    mask_d    = mask_q;
    cnt_d     = cnt_q;
    case (state_q)
      S_IDLE: begin
        if (accept && (req_type_i == REQ_RUN)) begin
          rem_d = (run_bad) ? '0 : req_mask;
        end
      end
      S_ERR: begin
        emit      = 1'b1;
        emit_st   = err_q;
        emit_last = 1'b1;
      end
      S_LOOK: begin
        mask_d = (vld_hit_q ? rdata : '0) & CMASK;
        cnt_d  = pos_q[CFG_THREAD];
      end
      S_STRIP: begin
        if (cnt_q != '0) begin
          mask_d = mask_q & (mask_q - MASK_W'(1));
          cnt_d  = cnt_q - DW'(1);
        end else begin
          emit      = pick_hit;
          emit_cpu  = pick_cpu;
          emit_last = (rem_after == '0);
          rem_d     = rem_after;
        end
      end
      S_REPORT: begin
        emit      = 1'b1;
        emit_cpu  = rep_cpu;
        emit_st   = ST_UNPLACED;
        emit_last = (rep_after == '0);
        rem_d     = rep_after;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      order_q <= '0;
      err_q   <= ST_BAD;
      rem_q   <= '0;
      for (int d = 0; d < NDIM; d++) begin
        pos_q[d] <= '0;
        lim_q[d] <= '0;
      end
      for (int e = 0; e < DEPTH; e++) begin
        vld_q[e] <= 1'b0;
      end
    end else begin
      state_q <= state_d;
      rem_q   <= rem_d;
      if (accept && (req_type_i == REQ_WRITE) && map_ok) begin
        vld_q[waddr] <= 1'b1;
      end
      if (accept && (req_type_i == REQ_RUN)) begin
        order_q <= dim_order_i;
        err_q   <= run_bad ? ST_BAD : ST_EMPTY;
        for (int d = 0; d < NDIM; d++) begin
          pos_q[d] <= '0;
          lim_q[d] <= lim_sel[d];
        end
      end
      // Advance the counter once a position has been handled; a wrap widens the limits.
      if ((state_q == S_STRIP) && (cnt_q == '0) && (rem_after != '0) && !(origin && full)) begin
        pos_q <= pos_n;
        if (origin) begin
          lim_q <= ext;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    mask_q <= mask_d;
    cnt_q  <= cnt_d;
    if (state_q == S_READ) begin
      vld_hit_q <= vld_q[raddr];
    end
  end

  // Result register: every result beat is shown for exactly one cycle.
  logic            res_valid_q;
  logic [ID_W-1:0] res_cpu_q;
  logic [1:0]      res_st_q;
  logic            res_last_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_valid_q <= 1'b0;
    end else begin
      res_valid_q <= emit;
    end
  end

  always_ff @(posedge clk_i) begin
    res_cpu_q  <= emit_cpu;
    res_st_q   <= emit_st;
    res_last_q <= emit_last;
  end

  assign result_valid_o = res_valid_q;
  assign cpu_id_o       = res_cpu_q;
  assign status_o       = res_st_q;
  assign last_o         = res_last_q;

endmodule

`default_nettype wire

>>> rtl/tocp_ram.sv
// Generic single-write, single-read RAM with a registered read port.
// No dependencies.
`default_nettype none

module tocp_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 128,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AW-1:0]    waddr_i,
  input  wire logic [WIDTH-1:0] wdata_i,
  input  wire logic             re_i,
  input  wire logic [AW-1:0]    raddr_i,
  output logic      [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

`default_nettype wire

>>> rtl/tocp_checker.sv
// Port-level checker for the topology-ordered CPU placement unit, with its bind.
// Depends on tocp_pkg and topology_ordered_cpu_placement_unit.
`default_nettype none

module tocp_checker (
  input wire logic       clk_i,
  input wire logic       rst_ni,
  input wire logic       start,
  input wire logic       busy,
  input wire logic       req_type_i,
  input wire logic       result_valid_o,
  input wire logic [1:0] status_o,
  input wire logic       last_o
);

  import tocp_pkg::*;

  // An error or empty-request beat is always the only beat of its run.
  a_err_is_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_valid_o && (status_o == ST_BAD || status_o == ST_EMPTY)) |-> last_o)
    else $error("error beat without last");

  // The last beat of a run is never directly followed by another beat.
  a_gap_after_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_valid_o && last_o) |=> !result_valid_o)
    else $error("beat directly after last");

  // A run still has work after a beat that is not its last.
  a_busy_mid_run: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_valid_o && !last_o) |-> busy)
    else $error("idle in the middle of a run");

  // A map write never produces a result.
  a_write_silent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy && req_type_i == REQ_WRITE) |=> !result_valid_o)
    else $error("result after a map write");

endmodule

bind topology_ordered_cpu_placement_unit tocp_checker u_tocp_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .start          (start),
  .busy           (busy),
  .req_type_i     (req_type_i),
  .result_valid_o (result_valid_o),
  .status_o       (status_o),
  .last_o         (last_o)
);

`default_nettype wire

>>> dv/topology_ordered_cpu_placement_unit_tb.sv
// Testbench for the topology-ordered CPU placement unit: directed and random beats,
// checked against a scoreboard that predicts every result. Depends on tocp_pkg and the RTL.
`default_nettype none

module topology_ordered_cpu_placement_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import tocp_pkg::*;

  localparam int MAP_DEPTH = NODE_MAX_DEF * TILE_MAX_DEF * CORE_MAX_DEF;

  // One request beat, with every payload field whether or not its kind uses it.
  typedef struct {
    logic       kind;
    logic [1:0] node;
    logic [1:0] tile;
    logic [2:0] core;
    logic [63:0] core_cpus;
    logic [63:0] requested;
    logic [7:0] order;
    logic [2:0] node_lim;
    logic [2:0] tile_lim;
    logic [3:0] core_lim;
    logic [2:0] thread_lim;
  } placement_req_t;

  typedef struct {
    logic [ID_W-1:0] cpu_id;
    logic [1:0]      status;
    logic            last_beat;
  } placement_res_t;

  // The scoreboard keeps its own copy of the extents and the core map and walks the
  // same mixed-radix counter as the unit, queueing every result a run should produce.
  class placement_scoreboard;
    logic [3:0]     extent_reg[NDIM];
    logic [63:0]    core_map[MAP_DEPTH];
    placement_res_t expected_q[$];
    int mismatches;
    int checked;

    function new();
      extent_reg[CFG_NODE]   = CFG_NODE_RST;
      extent_reg[CFG_TILE]   = CFG_TILE_RST;
      extent_reg[CFG_CORE]   = CFG_CORE_RST;
      extent_reg[CFG_THREAD] = CFG_THREAD_RST;
      foreach (core_map[i]) core_map[i] = '0;
      mismatches = 0;
      checked = 0;
    endfunction

    function void write_cfg(int idx, logic [3:0] data);
      // Node, tile and thread extents are three bits wide.
      extent_reg[idx] = (idx == CFG_CORE) ? data : {1'b0, data[2:0]};
    endfunction

    // Extent as the unit uses it: zero counts as one, large values clamp.
    function int extent(int d);
      int dmax;
      int v;
      dmax = (d == CFG_NODE) ? NODE_MAX_DEF : (d == CFG_TILE) ? TILE_MAX_DEF :
             (d == CFG_CORE) ? CORE_MAX_DEF : THREAD_MAX_DEF;
      v = extent_reg[d];
      if (v == 0) return 1;
      if (v > dmax) return dmax;
      return v;
    endfunction

    // Bit position of the n-th set bit counting from zero, or -1.
    function int nth_set(logic [63:0] m, int n);
      for (int b = 0; b < 64; b++) begin
        if (m[b]) begin
          if (n == 0) return b;
          n--;
        end
      end
      return -1;
    endfunction

    function void push(int cpu, logic [1:0] st);
      placement_res_t r;
      r.cpu_id = ID_W'(cpu);
      r.status = st;
      r.last_beat = 1'b0;
      expected_q.push_back(r);
    endfunction

    function void note_item(placement_req_t q);
      int ext[NDIM];
      int lim[NDIM];
      int pos[NDIM];
      int ord[NDIM];
      logic [3:0] seen;
      logic bad;
      logic [63:0] left;
      int first;
      int idx;
      int cpu;
      bit carry;
      bit origin;
      bit full;
      if (q.kind == REQ_WRITE) begin
        core_map[{q.node, q.tile, q.core}] = q.core_cpus;
        return;
      end
      first = expected_q.size();
      seen = '0;
      bad = 1'b0;
      for (int i = 0; i < NDIM; i++) begin
        ext[i] = extent(i);
        pos[i] = 0;
        ord[i] = q.order[2*i +: 2];
        if (seen[ord[i]]) bad = 1'b1;
        seen[ord[i]] = 1'b1;
      end
      lim[CFG_NODE]   = q.node_lim;
      lim[CFG_TILE]   = q.tile_lim;
      lim[CFG_CORE]   = q.core_lim;
      lim[CFG_THREAD] = q.thread_lim;
      for (int d = 0; d < NDIM; d++) begin
        if (lim[d] == 0) lim[d] = ext[d];
        if (lim[d] > ext[d]) bad = 1'b1;
      end
      left = q.requested;
      if (bad || left == 0) begin
        push(0, bad ? ST_BAD : ST_EMPTY);
      end else begin
        while (left != 0) begin
          idx = (pos[CFG_NODE] * TILE_MAX_DEF + pos[CFG_TILE]) * CORE_MAX_DEF + pos[CFG_CORE];
          cpu = nth_set(core_map[idx], pos[CFG_THREAD]);
          if (cpu >= 0 && left[cpu]) begin
            left[cpu] = 1'b0;
            push(cpu, ST_PLACED);
          end
          if (left == 0) break;
          carry = 1;
          for (int i = 0; i < NDIM && carry; i++) begin
            pos[ord[i]]++;
            if (pos[ord[i]] < lim[ord[i]]) carry = 0;
            else pos[ord[i]] = 0;
          end
          origin = 1;
          full = 1;
          for (int d = 0; d < NDIM; d++) begin
            if (pos[d] != 0) origin = 0;
            if (lim[d] != ext[d]) full = 0;
          end
          if (origin) begin
            // A wrap at full extents has seen every position, so whatever is left
            // cannot be placed and is reported in ascending order.
            if (full) begin
              for (int b = 0; b < 64; b++) if (left[b]) push(b, ST_UNPLACED);
              left = '0;
            end else begin
              for (int d = 0; d < NDIM; d++) lim[d] = ext[d];
            end
          end
        end
      end
      if (expected_q.size() > first) expected_q[expected_q.size()-1].last_beat = 1'b1;
    endfunction

    function void check_result(logic [ID_W-1:0] cpu_id, logic [1:0] st, logic last_beat);
      placement_res_t e;
      checked++;
      if (expected_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("ERROR: unexpected result beat cpu_id=%0d status=%0d last=%0b",
                   cpu_id, st, last_beat);
        return;
      end
      e = expected_q.pop_front();
      if (cpu_id !== e.cpu_id || st !== e.status || last_beat !== e.last_beat) begin
        mismatches++;
        if (mismatches <= 10)
          $display("ERROR: result beat expected cpu_id=%0d status=%0d last=%0b, got %0d %0d %0b",
                   e.cpu_id, e.status, e.last_beat, cpu_id, st, last_beat);
      end
    endfunction
  endclass

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we_i = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_idx_i = '0;
  logic [CFG_W-1:0] cfg_data_i = '0;
  logic start = 1'b0;
  logic busy;
  logic req_type_i = 1'b0;
  logic [1:0] map_node_i = '0;
  logic [1:0] map_tile_i = '0;
  logic [2:0] map_core_i = '0;
  logic [63:0] core_cpus_i = '0;
  logic [63:0] requested_cpus_i = '0;
  logic [7:0] dim_order_i = '0;
  logic [2:0] node_limit_i = '0;
  logic [2:0] tile_limit_i = '0;
  logic [3:0] core_limit_i = '0;
  logic [2:0] thread_limit_i = '0;
  logic result_valid_o;
  logic [ID_W-1:0] cpu_id_o;
  logic [1:0] status_o;
  logic last_o;

  placement_scoreboard sb = new();
  logic [63:0] mapped_cpus = '0;  // union of every mask written to the map
  int runs_sent = 0;
  int writes_sent = 0;

  always #5 clk_i = ~clk_i;

  topology_ordered_cpu_placement_unit u_top (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_idx_i, .cfg_data_i, .start, .busy,
    .req_type_i, .map_node_i, .map_tile_i, .map_core_i, .core_cpus_i,
    .requested_cpus_i, .dim_order_i, .node_limit_i, .tile_limit_i,
    .core_limit_i, .thread_limit_i, .result_valid_o, .cpu_id_o, .status_o, .last_o
  );

  // Results cannot be held off, so every strobed beat is checked at the edge ending it.
  always @(posedge clk_i) begin
    if (rst_ni && result_valid_o) sb.check_result(cpu_id_o, status_o, last_o);
  end

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  function automatic placement_req_t map_write(int n, int t, int c, logic [63:0] m);
    placement_req_t q;
    q = '{default: '0};
    q.kind = REQ_WRITE;
    q.node = 2'(n);
    q.tile = 2'(t);
    q.core = 3'(c);
    q.core_cpus = m;
    q.requested = rand64();
    return q;
  endfunction

  function automatic placement_req_t run_req(logic [63:0] req, logic [7:0] ord,
                                             int nl, int tl, int cl, int thl);
    placement_req_t q;
    q = '{default: '0};
    q.kind = REQ_RUN;
    q.requested = req;
    q.order = ord;
    q.node_lim = 3'(nl);
    q.tile_lim = 3'(tl);
    q.core_lim = 4'(cl);
    q.thread_lim = 3'(thl);
    q.node = 2'($urandom);
    q.tile = 2'($urandom);
    q.core = 3'($urandom);
    q.core_cpus = rand64();
    return q;
  endfunction

  // Presents one beat, optionally after a gap, and holds it until the unit takes it.
  // Called and returning in a step that follows a rising edge.
  task automatic send_beat(placement_req_t q, int gap_pct);
    if ($urandom_range(99) < gap_pct) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk_i);
    end
    start <= 1'b1;
    req_type_i <= q.kind;
    map_node_i <= q.node;
    map_tile_i <= q.tile;
    map_core_i <= q.core;
    core_cpus_i <= q.core_cpus;
    requested_cpus_i <= q.requested;
    dim_order_i <= q.order;
    node_limit_i <= q.node_lim;
    tile_limit_i <= q.tile_lim;
    core_limit_i <= q.core_lim;
    thread_limit_i <= q.thread_lim;
    do @(posedge clk_i); while (busy);
    sb.note_item(q);
    if (q.kind == REQ_WRITE) begin
      writes_sent++;
      mapped_cpus |= q.core_cpus;
    end else begin
      runs_sent++;
    end
  endtask

  // Drains every expected result, then lets the unit settle before touching registers.
  task automatic drain();
    start <= 1'b0;
    do @(posedge clk_i); while (sb.expected_q.size() != 0 || busy);
    repeat (16) @(posedge clk_i);
  endtask

  task automatic write_extents(logic [3:0] ne, logic [3:0] te, logic [3:0] ce, logic [3:0] he);
    logic [3:0] v[NDIM];
    v = '{ne, te, ce, he};
    for (int i = 0; i < NDIM; i++) begin
      cfg_we_i <= 1'b1;
      cfg_idx_i <= CFG_IDX_W'(i);
      cfg_data_i <= v[i];
      @(posedge clk_i);
      sb.write_cfg(i, v[i]);
    end
    cfg_we_i <= 1'b0;
  endtask

  // Random beat: map writes, or mostly well-formed runs over CPUs written to the map, with
  // some broken orders, out-of-range limits, empty and unplaceable requests.
  function automatic placement_req_t random_beat();
    logic [63:0] m;
    logic [63:0] req;
    logic [7:0] ord;
    int p[NDIM];
    int lim[NDIM];
    int j;
    int tmp;
    if ($urandom_range(99) < 35) begin
      case ($urandom_range(3))
        0: m = '0;
        1: m = rand64();
        default: begin
          m = '0;
          repeat ($urandom_range(1, 4)) m[$urandom_range(63)] = 1'b1;
        end
      endcase
      return map_write($urandom_range(3), $urandom_range(3), $urandom_range(7), m);
    end
    p = '{0, 1, 2, 3};
    for (int i = NDIM - 1; i > 0; i--) begin
      j = $urandom_range(i);
      tmp = p[i];
      p[i] = p[j];
      p[j] = tmp;
    end
    ord = {2'(p[3]), 2'(p[2]), 2'(p[1]), 2'(p[0])};
    if ($urandom_range(99) < 10) ord = 8'($urandom);
    for (int d = 0; d < NDIM; d++) begin
      if ($urandom_range(99) < 8) lim[d] = (d == CFG_CORE) ? $urandom_range(15) : $urandom_range(7);
      else lim[d] = $urandom_range(sb.extent(d));
    end
    case ($urandom_range(9))
      0: req = '0;
      1, 2: req = rand64();
      default: req = rand64() & mapped_cpus;
    endcase
    return run_req(req, ord, lim[0], lim[1], lim[2], lim[3]);
  endfunction

  initial begin
    logic [3:0] phase_ext[6][NDIM];
    int phase_gap[6];
    phase_ext = '{'{1, 1, 1, 1}, '{4, 2, 5, 3}, '{0, 7, 15, 7},
                  '{4, 4, 8, 4}, '{3, 4, 2, 1}, '{4, 4, 8, 4}};
    phase_gap = '{24, 24, 69, 69, 0, 0};
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed beats at the reset extents.
    send_beat(map_write(0, 0, 0, 64'hF), 0);
    send_beat(map_write(3, 3, 7, 64'hF000_0000_0000_0000), 0);
    send_beat(map_write(1, 2, 5, '1), 0);
    send_beat(map_write(2, 1, 3, '0), 0);   // absent core
    send_beat(map_write(0, 1, 0, 64'h30), 0);
    send_beat(run_req(64'hF000_0000_0000_003F, 8'hE4, 0, 0, 0, 0), 0);  // scatter
    send_beat(run_req(64'hF000_0000_0000_003F, 8'h1B, 0, 0, 0, 0), 0);  // compact
    send_beat(run_req(64'h3, 8'h1B, 1, 1, 2, 2), 0);                   // narrow first sweep
    send_beat(run_req(64'h1, 8'h00, 0, 0, 0, 0), 0);                   // repeated order codes
    send_beat(run_req(64'h1, 8'hE4, 5, 0, 0, 0), 0);                   // node limit too big
    send_beat(run_req(64'h1, 8'hE4, 0, 7, 15, 7), 0);                  // several limits too big
    send_beat(run_req('0, 8'hE4, 0, 0, 0, 0), 0);                      // empty request
    send_beat(run_req(64'h0000_0100_0000_0001, 8'hE4, 4, 4, 8, 4), 0); // one CPU unplaceable
    send_beat(run_req('1, 8'h1B, 0, 0, 0, 0), 0);                      // every CPU requested
    send_beat(run_req('1, 8'hE4, 1, 1, 1, 1), 0);
    send_beat(map_write(3, 3, 7, '0), 0);
    send_beat(run_req(64'hF000_0000_0000_0000, 8'hE4, 0, 0, 0, 0), 0);

    // Random phases, each with an extent setting and a sender idling rate.
    for (int ph = 0; ph < 6; ph++) begin
      drain();
      write_extents(phase_ext[ph][0], phase_ext[ph][1], phase_ext[ph][2], phase_ext[ph][3]);
      repeat (19) send_beat(random_beat(), phase_gap[ph]);
    end

    drain();
    repeat (50) @(posedge clk_i);
    $display("Covered %0d runs and %0d map writes over six extent settings; %0d result beats.",
             runs_sent, writes_sent, sb.checked);
    if (sb.mismatches == 0 && sb.expected_q.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("%0d mismatches, %0d results missing", sb.mismatches, sb.expected_q.size());
      $display("Test completed with failures");
    end
    $finish;
  end

  // Watchdog well beyond the slowest legal run.
  initial begin
    #50ms;
    $display("Timeout with %0d results outstanding", sb.expected_q.size());
    $display("Test completed with failures");
    $finish;
  end

endmodule

`default_nettype wire

>>> files.f
rtl/tocp_pkg.sv
rtl/tocp_ram.sv
rtl/topology_ordered_cpu_placement_unit.sv
rtl/tocp_checker.sv
dv/topology_ordered_cpu_placement_unit_tb.sv
